FILE: rtl/multi_channel_servo_pwm_top_macros.svh
// Assertion macros for the multi-channel servo PWM block.
// Used by multi_channel_servo_pwm_top.sv; no other dependencies.
`ifndef MULTI_CHANNEL_SERVO_PWM_TOP_MACROS_SVH
`define MULTI_CHANNEL_SERVO_PWM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/svp_pkg.sv
// Shared types and constants of the multi-channel servo PWM block.
// No dependencies; used by svp_cell, svp_ctrl and the top level.
package svp_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_SET  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_ENABLE = 1'b0,
    CFG_PERIOD = 1'b1
  } cfg_idx_e;

  // Controller sequence.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_RUN,
    ST_DONE
  } ctrl_state_e;

  // Field widths.
  localparam int unsigned ChanW   = 4;
  localparam int unsigned AngleW  = 8;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned HighW   = 11;
  localparam int unsigned SDataW  = 32;
  localparam int unsigned SUserW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Pulse law: high time = angle * SlopeNum / SlopeDen + PulseBase.
  localparam logic [AngleW-1:0] AngleMax  = 8'd180;
  localparam logic [7:0]        SlopeNum  = 8'd190;
  localparam int unsigned       SlopeDen  = 18;
  localparam logic [TimeW-1:0]  PulseBase = 16'd500;
  localparam logic [TimeW-1:0]  PeriodReset = 16'd20000;

  // Reciprocal of SlopeDen; exact for products below 74898 (max is 34200).
  localparam int unsigned RecipShift = 20;
  localparam logic [15:0] SlopeRecip =
    16'(((1 << RecipShift) + SlopeDen - 1) / SlopeDen);

  // Command that walks along the row of channel cells.
  typedef struct packed {
    logic              valid;
    req_e              req;
    logic [ChanW-1:0]  channel;
    logic [AngleW-1:0] angle;
    logic [TimeW-1:0]  high;
    logic [TimeW-1:0]  low;
    logic [TimeW-1:0]  delta;
    logic [AngleW-1:0] angle_res;
  } cmd_t;

endpackage

FILE: rtl/svp_cell.sv
// One servo channel: timer state plus one stage of the command row.
// Depends on svp_pkg.
module svp_cell #(
  parameter logic [3:0] CELL_IDX = 4'd0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  svp_pkg::cmd_t cmd_i,
  output svp_pkg::cmd_t cmd_o,
  output logic          level_o
);

  svp_pkg::cmd_t                   cmd_d, cmd_q;
  logic                            level_d, level_q;
  logic [svp_pkg::TimeW-1:0]       elapsed_d, elapsed_q;
  logic [svp_pkg::TimeW-1:0]       high_d, high_q;
  logic [svp_pkg::TimeW-1:0]       low_d, low_q;
  logic [svp_pkg::AngleW-1:0]      angle_d, angle_q;
  logic [svp_pkg::TimeW:0]         sum;
  logic [svp_pkg::TimeW-1:0]       sat;
  logic [svp_pkg::TimeW-1:0]       limit;
  logic                            hit;

  // Saturating advance of the elapsed time and the limit of the current phase.
  assign sum   = {1'b0, elapsed_q} + {1'b0, cmd_i.delta};
  assign sat   = sum[svp_pkg::TimeW] ? {svp_pkg::TimeW{1'b1}} : sum[svp_pkg::TimeW-1:0];
  assign limit = level_q ? high_q : low_q;
  assign hit   = (cmd_i.channel == CELL_IDX);

  // Act on the command as it passes through this cell.
  always_comb begin
    cmd_d     = cmd_i;
    level_d   = level_q;
    elapsed_d = elapsed_q;
    high_d    = high_q;
    low_d     = low_q;
    angle_d   = angle_q;
    if (cmd_i.valid) begin
      unique case (cmd_i.req)
        svp_pkg::REQ_TICK: begin
          if (!enable_i) begin
            level_d   = 1'b0;
            elapsed_d = '0;
          end else if (sat > limit) begin
            level_d   = ~level_q;
            elapsed_d = '0;
          end else begin
            elapsed_d = sat;
          end
        end
        svp_pkg::REQ_SET: begin
          if (hit) begin
            angle_d = cmd_i.angle;
            high_d  = cmd_i.high;
            low_d   = cmd_i.low;
          end
        end
        svp_pkg::REQ_READ: begin
          if (hit) begin
            cmd_d.angle_res = angle_q;
          end
        end
        svp_pkg::REQ_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Channel state and the command stage toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q     <= '0;
      level_q   <= 1'b0;
      elapsed_q <= '0;
      high_q    <= '0;
      low_q     <= '0;
      angle_q   <= '0;
    end else begin
      cmd_q     <= cmd_d;
      level_q   <= level_d;
      elapsed_q <= elapsed_d;
      high_q    <= high_d;
      low_q     <= low_d;
      angle_q   <= angle_d;
    end
  end

  assign cmd_o   = cmd_q;
  assign level_o = level_q;

endmodule

FILE: rtl/svp_ctrl.sv
// Sequencer of the servo PWM block: input transfer, pulse-width arithmetic,
// launch into the cell row and the output register. Depends on svp_pkg.
module svp_ctrl #(
  parameter int unsigned NUM_CHANNELS = 10,
  parameter int unsigned M_DATA_W     = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [svp_pkg::SDataW-1:0]    s_axis_tdata,
  input  logic [svp_pkg::SUserW-1:0]    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [M_DATA_W-1:0]           m_axis_tdata,
  input  logic [svp_pkg::TimeW-1:0]     period_i,
  input  logic [NUM_CHANNELS-1:0]       levels_i,
  input  svp_pkg::cmd_t                 chain_i,
  output svp_pkg::cmd_t                 cmd_o
);

  svp_pkg::ctrl_state_e            state_d, state_q;
  svp_pkg::req_e                   req_q;
  logic [svp_pkg::ChanW-1:0]       chan_q;
  logic [svp_pkg::AngleW-1:0]      ang_q, angle_res_q;
  logic [svp_pkg::TimeW-1:0]       delta_q, prod_q;
  logic [svp_pkg::HighW-1:0]       quot_q;
  logic [svp_pkg::AngleW-1:0]      ang_in, ang_clamp;
  logic [31:0]                     recip_prod;
  logic [svp_pkg::TimeW-1:0]       high_w, low_w;
  logic                            in_xfer, out_load;
  logic                            out_valid_q;
  logic [NUM_CHANNELS-1:0]         out_levels_q;
  logic [svp_pkg::AngleW-1:0]      out_angle_q;

  // Input unpacking and clamping of the requested angle.
  assign ang_in    = s_axis_tdata[11:4];
  assign ang_clamp = (ang_in > svp_pkg::AngleMax) ? svp_pkg::AngleMax : ang_in;
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // Division by the slope denominator through its reciprocal.
  assign recip_prod = 32'(prod_q) * 32'(svp_pkg::SlopeRecip);

  // High and low time of the addressed channel.
  assign high_w = svp_pkg::TimeW'(quot_q) + svp_pkg::PulseBase;
  assign low_w  = (period_i > high_w) ? (period_i - high_w) : '0;

  // Next state and handshakes.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      svp_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = svp_pkg::ST_DIV;
        end
      end
      svp_pkg::ST_DIV: begin
        state_d = svp_pkg::ST_ISSUE;
      end
      svp_pkg::ST_ISSUE: begin
        state_d = svp_pkg::ST_RUN;
      end
      svp_pkg::ST_RUN: begin
        if (chain_i.valid) begin
          state_d = svp_pkg::ST_DONE;
        end
      end
      svp_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = svp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = svp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item registers and the arithmetic steps.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q   <= svp_pkg::req_e'(s_axis_tuser);
      chan_q  <= s_axis_tdata[3:0];
      ang_q   <= ang_clamp;
      delta_q <= s_axis_tdata[27:12];
      prod_q  <= svp_pkg::TimeW'(ang_clamp) * svp_pkg::TimeW'(svp_pkg::SlopeNum);
    end
    if (state_q == svp_pkg::ST_DIV) begin
      quot_q <= recip_prod[svp_pkg::RecipShift +: svp_pkg::HighW];
    end
    if (state_q == svp_pkg::ST_RUN && chain_i.valid) begin
      angle_res_q <= chain_i.angle_res;
    end
  end

  // Command launched into the first cell.
  always_comb begin
    cmd_o.valid     = (state_q == svp_pkg::ST_ISSUE);
    cmd_o.req       = req_q;
    cmd_o.channel   = chan_q;
    cmd_o.angle     = ang_q;
    cmd_o.high      = high_w;
    cmd_o.low       = low_w;
    cmd_o.delta     = delta_q;
    cmd_o.angle_res = '0;
  end

  // Output register; the levels are sampled once the row has settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_levels_q <= levels_i;
      out_angle_q  <= angle_res_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_DATA_W'({out_angle_q, out_levels_q});

endmodule

FILE: rtl/multi_channel_servo_pwm_top.sv
// Channel     Direction  Transfer when                  Payload
// s_axis      in         s_axis_tvalid & s_axis_tready  tuser req_type, tdata channel/angle/delta
// m_axis      out        m_axis_tvalid & m_axis_tready  tdata pin_levels, angle_out
// cfg         in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// One item is in flight at a time: the next input transfer is taken once the
// result of the last item is in the output register. ST_DIV finishes the
// pulse-width division, ST_ISSUE launches the command, the command walks the
// row of channel cells one cell per cycle, and ST_DONE loads the output register.
// Reset is asynchronous and active low; all channels start low with zero times,
// the period register at 20000. A stalled output holds the sequencer until the
// result register frees up; configuration is always taken.
// Top level of the multi-channel servo PWM block.
// Depends on svp_pkg, svp_cell, svp_ctrl and the assertion macro header.
`include "multi_channel_servo_pwm_top_macros.svh"

module multi_channel_servo_pwm_top #(
  parameter int unsigned NUM_CHANNELS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // channel [3:0], angle_in [11:4], delta_us [27:12], zeros above
  input  logic [svp_pkg::SDataW-1:0]          s_axis_tdata,
  // req_type [1:0]
  input  logic [svp_pkg::SUserW-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pin_levels [NUM_CHANNELS-1:0], angle_out above it, zeros to a whole byte
  output logic [((NUM_CHANNELS+8+7)/8)*8-1:0] m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [svp_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned MDataW = ((NUM_CHANNELS + 8 + 7) / 8) * 8;

  logic [NUM_CHANNELS-1:0]       enable_q;
  logic [svp_pkg::TimeW-1:0]     period_q;
  logic [NUM_CHANNELS-1:0]       levels;
  logic [NUM_CHANNELS-1:0]       chain_valid;
  svp_pkg::cmd_t                 chain [NUM_CHANNELS+1];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      period_q <= svp_pkg::PeriodReset;
    end else if (cfg_valid_i) begin
      unique case (svp_pkg::cfg_idx_e'(cfg_index_i))
        svp_pkg::CFG_ENABLE: enable_q <= cfg_data_i[NUM_CHANNELS-1:0];
        svp_pkg::CFG_PERIOD: period_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequencer and output register.
  svp_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .M_DATA_W     (MDataW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .period_i (period_q),
    .levels_i (levels & enable_q),
    .chain_i  (chain[NUM_CHANNELS]),
    .cmd_o    (chain[0])
  );

  // Row of channel cells; each passes the command to its neighbor.
  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    svp_cell #(
      .CELL_IDX (4'(g))
    ) u_chan (
      .clk_i,
      .rst_ni,
      .enable_i (enable_q[g]),
      .cmd_i    (chain[g]),
      .cmd_o    (chain[g+1]),
      .level_o  (levels[g])
    );
    assign chain_valid[g] = chain[g+1].valid;
  end

  // Only one command travels the row, and never while input is open.
  `SVP_ASSERT_NOW(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(chain_valid), "several commands in the row")
  `SVP_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open right after a transfer")
  `SVP_ASSERT_NOW(a_row_busy, clk_i, rst_ni, chain_valid != '0, !s_axis_tready, "input open while the row is busy")

endmodule

FILE: sim/tb_multi_channel_servo_pwm_top.sv
// Self-checking testbench for the multi-channel servo PWM block.
// Depends on svp_pkg and multi_channel_servo_pwm_top; predicts every result in-line.
module tb_multi_channel_servo_pwm_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumChannels  = 10;
  localparam int unsigned OutW         = ((NumChannels + 8 + 7) / 8) * 8;
  localparam int unsigned AngleLimit   = 180;
  localparam int unsigned PulseSlope   = 190;
  localparam int unsigned PulseDiv     = 18;
  localparam int unsigned PulseMinUs   = 500;
  localparam int unsigned ElapsedMax   = 65535;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseItems   = 96;

  // One expected result: channel levels in the low bits, angle above them.
  typedef struct packed {
    logic [7:0]             angle_out;
    logic [NumChannels-1:0] pin_levels;
  } servo_result_t;

  // Clock, reset and the stimulus side of every channel.
  logic                       clk_i     = 1'b0;
  logic                       rst_ni    = 1'b0;
  logic                       s_tvalid  = 1'b0;
  logic [svp_pkg::SDataW-1:0] s_tdata   = '0;
  logic [svp_pkg::SUserW-1:0] s_tuser   = svp_pkg::REQ_TICK;
  logic                       m_tready  = 1'b0;
  logic                       cfg_valid = 1'b0;
  svp_pkg::cfg_idx_e          cfg_index = svp_pkg::CFG_ENABLE;
  logic [svp_pkg::CfgDataW-1:0] cfg_data = '0;

  logic              s_axis_tready;
  logic              m_axis_tvalid;
  logic [OutW-1:0]   m_axis_tdata;
  logic              cfg_ready_o;

  // Shared control of the run.
  bit          quiet_mode = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  servo_result_t pending_results_q[$];

  // Predicted channel state and register contents.
  logic [NumChannels-1:0] pwm_enable_mask = '0;
  logic [15:0]            pwm_period_us   = 16'd20000;
  logic [15:0] pwm_high_us    [NumChannels] = '{default: '0};
  logic [15:0] pwm_low_us     [NumChannels] = '{default: '0};
  logic        pwm_level      [NumChannels] = '{default: 1'b0};
  logic [15:0] pwm_elapsed_us [NumChannels] = '{default: '0};
  logic [7:0]  pwm_angle      [NumChannels] = '{default: '0};

  multi_channel_servo_pwm_top #(
    .NUM_CHANNELS(NumChannels)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Free-running clock with a 4 ns period.
  always #2 clk_i = ~clk_i;

  // Applies one request to the predicted state and returns the result it yields.
  function automatic servo_result_t predict_servo_item(input svp_pkg::req_e req,
                                                       input logic [3:0] ch,
                                                       input logic [7:0] ang,
                                                       input logic [15:0] delta);
    servo_result_t res;
    int unsigned   clamped;
    int unsigned   pulse;
    int unsigned   total;
    int unsigned   limit;
    res = '0;
    case (req)
      svp_pkg::REQ_TICK: begin
        for (int c = 0; c < NumChannels; c++) begin
          if (!pwm_enable_mask[c]) begin
            // A disabled channel is held low with its timer cleared.
            pwm_level[c] = 1'b0;
            pwm_elapsed_us[c] = '0;
          end else begin
            total = pwm_elapsed_us[c] + delta;
            if (total > ElapsedMax) total = ElapsedMax;
            limit = pwm_level[c] ? pwm_high_us[c] : pwm_low_us[c];
            if (total > limit) begin
              pwm_level[c] = ~pwm_level[c];
              total = 0;
            end
            pwm_elapsed_us[c] = total[15:0];
          end
        end
      end
      svp_pkg::REQ_SET: begin
        if (ch < NumChannels) begin
          clamped = (ang > AngleLimit) ? AngleLimit : ang;
          pulse = clamped * PulseSlope / PulseDiv + PulseMinUs;
          pwm_angle[ch] = clamped[7:0];
          pwm_high_us[ch] = pulse[15:0];
          pwm_low_us[ch] = (pwm_period_us > pulse) ? pwm_period_us - pulse[15:0] : '0;
        end
      end
      svp_pkg::REQ_READ: begin
        if (ch < NumChannels) res.angle_out = pwm_angle[ch];
      end
      default: ;
    endcase
    for (int c = 0; c < NumChannels; c++) begin
      res.pin_levels[c] = pwm_level[c] & pwm_enable_mask[c];
    end
    return res;
  endfunction

  // Sends one request after a random gap (none in quiet mode) and records its expected result.
  task automatic send_servo_request(input svp_pkg::req_e req, input logic [3:0] ch,
                                    input logic [7:0] ang, input logic [15:0] delta);
    int unsigned gap;
    gap = quiet_mode ? 0 : $urandom_range(19, 0);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {4'b0, delta, ang, ch};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results_q.push_back(predict_servo_item(req, ch, ang, delta));
  endtask

  // Stops sending and waits until every expected result has been seen.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results_q.size() != 0);
  endtask

  // Writes both registers back to back while the block is idle.
  task automatic apply_settings(input logic [15:0] enable_word, input logic [15:0] period_word);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= svp_pkg::CFG_ENABLE;
    cfg_data  <= enable_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    pwm_enable_mask = enable_word[NumChannels-1:0];
    cfg_index <= svp_pkg::CFG_PERIOD;
    cfg_data  <= period_word;
    do @(posedge clk_i); while (!cfg_ready_o);
    pwm_period_us = period_word;
    cfg_valid <= 1'b0;
  endtask

  // Angle storage: clamping, reads, ignored channels and the unused code.
  task automatic test_angle_storage();
    send_servo_request(svp_pkg::REQ_READ, 4'd0, 8'd0, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd0, 8'd0, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd9, 8'd255, 16'hFFFF);
    send_servo_request(svp_pkg::REQ_SET, 4'd1, 8'd180, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd2, 8'd181, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd12, 8'd77, 16'd0);
    send_servo_request(svp_pkg::REQ_READ, 4'd9, 8'd0, 16'd0);
    send_servo_request(svp_pkg::REQ_READ, 4'd15, 8'hFF, 16'hFFFF);
    send_servo_request(svp_pkg::REQ_NONE, 4'd3, 8'hFF, 16'hFFFF);
    // Ticks with every channel disabled leave all levels low.
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd5000);
  endtask

  // Timing corners: zero and saturating ticks, the shortest period above the longest
  // pulse, the longest period, and a period shorter than the pulse.
  task automatic test_timing_edges();
    apply_settings(16'hFFFF, 16'd2401);
    send_servo_request(svp_pkg::REQ_SET, 4'd3, 8'd180, 16'd0);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd0);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd1);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd2);
    send_servo_request(svp_pkg::REQ_TICK, 4'd15, 8'hFF, 16'hFFFF);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'hFFFF);
    apply_settings(16'h02AA, 16'hFFFF);
    send_servo_request(svp_pkg::REQ_SET, 4'd5, 8'd90, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd6, 8'd0, 16'd0);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'hFFFF);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd0);
    apply_settings(16'h0155, 16'd1000);
    send_servo_request(svp_pkg::REQ_SET, 4'd0, 8'd180, 16'd0);
    send_servo_request(svp_pkg::REQ_SET, 4'd2, 8'd50, 16'd0);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd1);
    send_servo_request(svp_pkg::REQ_TICK, 4'd0, 8'd0, 16'd3000);
    send_servo_request(svp_pkg::REQ_READ, 4'd0, 8'd0, 16'd0);
  endtask

  // Random traffic over a series of register settings. Each phase first sets
  // every channel's angle, then mixes mostly ticks with sets, reads and noise.
  task automatic test_random_traffic();
    logic [15:0]   enable_word;
    logic [15:0]   period_word;
    logic [3:0]    ch;
    logic [7:0]    ang;
    logic [15:0]   delta;
    int unsigned   pick;
    svp_pkg::req_e req;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       enable_word = 16'h03FF;
        1:       enable_word = 16'h0000;
        default: enable_word = 16'($urandom_range(65535, 0));
      endcase
      case (phase)
        0:       period_word = 16'd2401;
        1:       period_word = 16'hFFFF;
        2:       period_word = 16'd20000;
        3:       period_word = 16'($urandom_range(2400, 0));
        default: period_word = 16'($urandom_range(65535, 2401));
      endcase
      apply_settings(enable_word, period_word);
      quiet_mode = (phase % 4 == 3);
      for (int c = 0; c < NumChannels; c++) begin
        ang = 8'($urandom_range(255, 0));
        send_servo_request(svp_pkg::REQ_SET, 4'(c), ang, 16'($urandom_range(65535, 0)));
      end
      for (int n = 0; n < PhaseItems; n++) begin
        // Once mid-run the sender holds off until everything has come back.
        if (phase == 5 && n == PhaseItems / 2) drain_results();
        pick = $urandom_range(99, 0);
        if (pick < 55) req = svp_pkg::REQ_TICK;
        else if (pick < 80) req = svp_pkg::REQ_SET;
        else if (pick < 95) req = svp_pkg::REQ_READ;
        else req = svp_pkg::REQ_NONE;
        ch = ($urandom_range(9, 0) != 0) ? 4'($urandom_range(NumChannels - 1, 0))
                                         : 4'($urandom_range(15, NumChannels));
        ang = 8'($urandom_range(255, 0));
        pick = $urandom_range(99, 0);
        if (pick < 70) delta = 16'($urandom_range(3000, 0));
        else if (pick < 90) delta = 16'($urandom_range(20000, 0));
        else delta = 16'($urandom_range(65535, 0));
        send_servo_request(req, ch, ang, delta);
      end
      quiet_mode = 1'b0;
    end
  endtask

  // Result side: random stalls outside quiet mode, then each transfer is checked field by field.
  initial begin : result_monitor
    int unsigned   stall;
    servo_result_t got;
    servo_result_t want;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(19, 0);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.pin_levels = m_axis_tdata[NumChannels-1:0];
      got.angle_out  = m_axis_tdata[NumChannels+7:NumChannels];
      if (pending_results_q.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: unexpected result, expected none, actual levels %03h angle %0d",
                 $time, got.pin_levels, got.angle_out);
      end else begin
        want = pending_results_q.pop_front();
        if (got.pin_levels !== want.pin_levels) begin
          mismatch_count++;
          $display("%0t ns: pin_levels mismatch, expected %03h, actual %03h",
                   $time, want.pin_levels, got.pin_levels);
        end
        if (got.angle_out !== want.angle_out) begin
          mismatch_count++;
          $display("%0t ns: angle_out mismatch, expected %0d, actual %0d",
                   $time, want.angle_out, got.angle_out);
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer on any channel ends the run.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
        (cfg_valid && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == StallLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, StallLimit);
      $display("tb_multi_channel_servo_pwm_top failed");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_angle_storage();
    test_timing_edges();
    test_random_traffic();
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_multi_channel_servo_pwm_top passed");
    end else begin
      $display("tb_multi_channel_servo_pwm_top failed");
    end
    $finish;
  end

endmodule
